FILE: sv/priority_round_robin_thread_scheduler_assert.svh
// assertion macros for the thread scheduler
`ifndef PRIORITY_ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define PRRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PRRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PRRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/prrs_pkg.sv
package prrs_pkg;

  // field widths
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned PRIO_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_OUT_W = 2;

  // highest priority code, larger codes saturate to it
  localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd2;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 3'd0,
    KIND_YIELD  = 3'd1,
    KIND_EXIT   = 3'd2,
    KIND_START  = 3'd3,
    KIND_SET    = 3'd4,
    KIND_GET    = 3'd5
  } kind_e;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_FREE    = 2'd1,
    STAT_STARTED    = 2'd2,
    STAT_NO_CURRENT = 2'd3
  } status_e;

  // slot states
  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RUNNABLE = 2'd1,
    SLOT_RUNNING  = 2'd2
  } slot_state_e;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_CREATE,
    OP_INIT_SELECT,
    OP_INIT_YIELD,
    OP_INIT_START,
    OP_SCAN,
    OP_READ_CUR,
    OP_APPLY_CREATE,
    OP_APPLY_YIELD,
    OP_APPLY_EXIT,
    OP_APPLY_START,
    OP_EXIT_RUN,
    OP_SET_PRIO,
    OP_GET_PRIO,
    OP_NO_CURRENT,
    OP_STARTED_ERR
  } dp_op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_TAIL,
    ST_APPLY,
    ST_EXIT_RUN,
    ST_RMW,
    ST_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              cur_valid;
    logic              started;
    logic              found;
    logic              scan_last;
  } dp_stat_t;

endpackage

FILE: sv/prrs_if.sv
// request channel
interface prrs_req_if;
  import prrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, kind, priority_req, input ready);
  modport sink   (input valid, kind, priority_req, output ready);
endinterface

// response channel
interface prrs_rsp_if;
  import prrs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] created_slot;
  logic                  running_valid;
  logic [SLOT_OUT_W-1:0] running_slot;
  logic [PRIO_W-1:0]     old_priority;
  logic                  all_done;

  modport source (output valid, status, created_slot, running_valid, running_slot,
                  old_priority, all_done, input ready);
  modport sink   (input valid, status, created_slot, running_valid, running_slot,
                  old_priority, all_done, output ready);
endinterface

FILE: sv/prrs_dp.sv
module prrs_dp #(
  parameter int unsigned THREAD_SLOTS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  prrs_pkg::dp_cmd_t                 cmd_i,
  output prrs_pkg::dp_stat_t                stat_o,
  input  logic [prrs_pkg::KIND_W-1:0]       kind_i,
  input  logic [prrs_pkg::PRIO_W-1:0]       priority_req_i,
  output logic [prrs_pkg::STATUS_W-1:0]     status_o,
  output logic [prrs_pkg::SLOT_OUT_W-1:0]   created_slot_o,
  output logic                              running_valid_o,
  output logic [prrs_pkg::SLOT_OUT_W-1:0]   running_slot_o,
  output logic [prrs_pkg::PRIO_W-1:0]       old_priority_o,
  output logic                              all_done_o
);
  import prrs_pkg::*;

  localparam int unsigned IW = $clog2(THREAD_SLOTS);
  localparam int unsigned SW = (IW > SLOT_OUT_W) ? IW : SLOT_OUT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(THREAD_SLOTS - 1);
  localparam logic [IW:0]   SLOTS_W  = (IW + 1)'(THREAD_SLOTS);

  // slot table: status and priority memories, valid bits in flops
  logic [1:0]        stat_mem [THREAD_SLOTS];
  logic [PRIO_W-1:0] prio_mem [THREAD_SLOTS];
  logic              valid_q  [THREAD_SLOTS];

  logic [1:0]        rd_stat_q;
  logic [PRIO_W-1:0] rd_prio_q;
  logic              rd_valid_q;
  logic [IW-1:0]     rd_addr_q;
  logic [IW-1:0]     rd_addr;

  logic              wr_stat_en;
  logic              wr_prio_en;
  logic [IW-1:0]     wr_addr;
  logic [1:0]        wr_stat;

  // request and scheduler state
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [IW-1:0]     ptr_q, ptr_d;
  logic [IW-1:0]     cur_q, cur_d;
  logic              cur_valid_q, cur_valid_d;
  logic              started_q, started_d;

  // scan state
  logic [IW-1:0]     base_q, base_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic              found_q, found_d;
  logic [IW-1:0]     best_q, best_d;
  logic [PRIO_W-1:0] best_prio_q, best_prio_d;
  logic              scan_rd_q;

  // result fields
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [IW-1:0]       res_created_q, res_created_d;
  logic [PRIO_W-1:0]   res_old_q, res_old_d;
  logic                res_done_q, res_done_d;

  // output register
  logic [STATUS_W-1:0]   out_status_q;
  logic [SLOT_OUT_W-1:0] out_created_q;
  logic                  out_run_valid_q;
  logic [SLOT_OUT_W-1:0] out_run_slot_q;
  logic [PRIO_W-1:0]     out_old_q;
  logic                  out_done_q;

  logic [IW:0]       scan_sum;
  logic [IW-1:0]     scan_addr;
  logic [IW-1:0]     best_next;
  logic [1:0]        ent_stat;
  logic [PRIO_W-1:0] ent_prio;
  logic [SW-1:0]     cur_ext;
  logic [SW-1:0]     created_ext;

  // scan address wraps around the table
  assign scan_sum  = {1'b0, base_q} + {1'b0, cnt_q};
  assign scan_addr = (scan_sum >= SLOTS_W) ? IW'(scan_sum - SLOTS_W) : scan_sum[IW-1:0];
  assign best_next = (best_q == LAST_IDX) ? '0 : best_q + IW'(1);

  // entries never written read as free with priority zero
  assign ent_stat = rd_valid_q ? rd_stat_q : SLOT_FREE;
  assign ent_prio = rd_valid_q ? rd_prio_q : '0;

  assign rd_addr = (cmd_i.op == OP_READ_CUR) ? cur_q : scan_addr;

  // next-state logic of the datapath
  always_comb begin
    kind_d        = kind_q;
    prio_d        = prio_q;
    ptr_d         = ptr_q;
    cur_d         = cur_q;
    cur_valid_d   = cur_valid_q;
    started_d     = started_q;
    base_d        = base_q;
    cnt_d         = cnt_q;
    found_d       = found_q;
    best_d        = best_q;
    best_prio_d   = best_prio_q;
    res_status_d  = res_status_q;
    res_created_d = res_created_q;
    res_old_d     = res_old_q;
    res_done_d    = res_done_q;
    wr_stat_en    = 1'b0;
    wr_prio_en    = 1'b0;
    wr_addr       = cur_q;
    wr_stat       = SLOT_FREE;

    // evaluate the entry read in the previous scan cycle
    if (scan_rd_q) begin
      if (kind_q == KIND_CREATE) begin
        if (!found_q && ent_stat == SLOT_FREE) begin
          found_d = 1'b1;
          best_d  = rd_addr_q;
        end
      end else begin
        if (ent_stat == SLOT_RUNNABLE && (!found_q || ent_prio > best_prio_q)) begin
          found_d     = 1'b1;
          best_d      = rd_addr_q;
          best_prio_d = ent_prio;
        end
      end
    end

    case (cmd_i.op)
      OP_LOAD: begin
        kind_d        = kind_i;
        prio_d        = (priority_req_i > PRIO_HIGH) ? PRIO_HIGH : priority_req_i;
        res_status_d  = STAT_OK;
        res_created_d = '0;
        res_old_d     = '0;
        res_done_d    = 1'b0;
      end
      OP_INIT_CREATE: begin
        base_d  = '0;
        cnt_d   = '0;
        found_d = 1'b0;
      end
      OP_INIT_SELECT: begin
        base_d  = ptr_q;
        cnt_d   = '0;
        found_d = 1'b0;
      end
      OP_INIT_YIELD: begin
        base_d     = ptr_q;
        cnt_d      = '0;
        found_d    = 1'b0;
        wr_stat_en = 1'b1;
        wr_addr    = cur_q;
        wr_stat    = SLOT_RUNNABLE;
      end
      OP_INIT_START: begin
        base_d    = ptr_q;
        cnt_d     = '0;
        found_d   = 1'b0;
        started_d = 1'b1;
      end
      OP_SCAN: begin
        cnt_d = (cnt_q == LAST_IDX) ? '0 : cnt_q + IW'(1);
      end
      OP_APPLY_CREATE: begin
        if (found_q) begin
          wr_stat_en    = 1'b1;
          wr_prio_en    = 1'b1;
          wr_addr       = best_q;
          wr_stat       = SLOT_RUNNABLE;
          res_created_d = best_q;
        end else begin
          res_status_d = STAT_NO_FREE;
        end
      end
      OP_APPLY_YIELD: begin
        wr_stat_en = 1'b1;
        wr_addr    = found_q ? best_q : cur_q;
        wr_stat    = SLOT_RUNNING;
        if (found_q) begin
          cur_d = best_q;
          ptr_d = best_next;
        end
      end
      OP_APPLY_EXIT: begin
        wr_stat_en = 1'b1;
        wr_addr    = cur_q;
        wr_stat    = SLOT_FREE;
        if (found_q) begin
          ptr_d = best_next;
        end else begin
          cur_valid_d = 1'b0;
          cur_d       = '0;
          res_done_d  = 1'b1;
        end
      end
      OP_EXIT_RUN: begin
        wr_stat_en = 1'b1;
        wr_addr    = best_q;
        wr_stat    = SLOT_RUNNING;
        cur_d      = best_q;
      end
      OP_APPLY_START: begin
        if (found_q) begin
          wr_stat_en  = 1'b1;
          wr_addr     = best_q;
          wr_stat     = SLOT_RUNNING;
          cur_d       = best_q;
          cur_valid_d = 1'b1;
          ptr_d       = best_next;
        end
      end
      OP_SET_PRIO: begin
        wr_prio_en = 1'b1;
        wr_addr    = cur_q;
        res_old_d  = ent_prio;
      end
      OP_GET_PRIO: begin
        res_old_d = ent_prio;
      end
      OP_NO_CURRENT: begin
        res_status_d = STAT_NO_CURRENT;
      end
      OP_STARTED_ERR: begin
        res_status_d = STAT_STARTED;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      started_q   <= 1'b0;
      scan_rd_q   <= 1'b0;
      found_q     <= 1'b0;
      kind_q      <= '0;
      valid_q     <= '{default: 1'b0};
    end else begin
      ptr_q       <= ptr_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      started_q   <= started_d;
      scan_rd_q   <= (cmd_i.op == OP_SCAN);
      found_q     <= found_d;
      kind_q      <= kind_d;
      if (wr_stat_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prio_q        <= prio_d;
    base_q        <= base_d;
    cnt_q         <= cnt_d;
    best_q        <= best_d;
    best_prio_q   <= best_prio_d;
    res_status_q  <= res_status_d;
    res_created_q <= res_created_d;
    res_old_q     <= res_old_d;
    res_done_q    <= res_done_d;
  end

  // slot table write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_stat_en) begin
      stat_mem[wr_addr] <= wr_stat;
    end
    if (wr_prio_en) begin
      prio_mem[wr_addr] <= prio_q;
    end
    rd_stat_q  <= stat_mem[rd_addr];
    rd_prio_q  <= prio_mem[rd_addr];
    rd_valid_q <= valid_q[rd_addr];
    rd_addr_q  <= rd_addr;
  end

  // output register
  assign cur_ext     = cur_valid_q ? SW'(cur_q) : '0;
  assign created_ext = SW'(res_created_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q    <= res_status_q;
      out_created_q   <= created_ext[SLOT_OUT_W-1:0];
      out_run_valid_q <= cur_valid_q;
      out_run_slot_q  <= cur_ext[SLOT_OUT_W-1:0];
      out_old_q       <= res_old_q;
      out_done_q      <= res_done_q;
    end
  end

  assign status_o        = out_status_q;
  assign created_slot_o  = out_created_q;
  assign running_valid_o = out_run_valid_q;
  assign running_slot_o  = out_run_slot_q;
  assign old_priority_o  = out_old_q;
  assign all_done_o      = out_done_q;

  // status to the controller
  assign stat_o.kind      = kind_q;
  assign stat_o.cur_valid = cur_valid_q;
  assign stat_o.started   = started_q;
  assign stat_o.found     = found_q;
  assign stat_o.scan_last = (cnt_q == LAST_IDX);

endmodule

FILE: sv/prrs_ctrl.sv
module prrs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  input  prrs_pkg::dp_stat_t stat_i,
  output prrs_pkg::dp_cmd_t  cmd_o
);
  import prrs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // output register can take a new result
  assign out_free = !out_valid_q || rsp_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.kind)
          KIND_CREATE: state_d = ST_SCAN;
          KIND_YIELD,
          KIND_EXIT:   state_d = stat_i.cur_valid ? ST_SCAN : ST_FINISH;
          KIND_START:  state_d = stat_i.started ? ST_FINISH : ST_SCAN;
          KIND_SET,
          KIND_GET:    state_d = stat_i.cur_valid ? ST_RMW : ST_FINISH;
          default:     state_d = ST_FINISH;
        endcase
      end
      ST_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (stat_i.kind == KIND_EXIT && stat_i.found) begin
          state_d = ST_EXIT_RUN;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_EXIT_RUN: begin
        state_d = ST_FINISH;
      end
      ST_RMW: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    req_ready_o    = 1'b0;
    cmd_o.op       = OP_NONE;
    cmd_o.out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = OP_LOAD;
        end
      end
      ST_DECODE: begin
        case (stat_i.kind)
          KIND_CREATE: cmd_o.op = OP_INIT_CREATE;
          KIND_YIELD:  cmd_o.op = stat_i.cur_valid ? OP_INIT_YIELD : OP_NO_CURRENT;
          KIND_EXIT:   cmd_o.op = stat_i.cur_valid ? OP_INIT_SELECT : OP_NO_CURRENT;
          KIND_START:  cmd_o.op = stat_i.started ? OP_STARTED_ERR : OP_INIT_START;
          KIND_SET,
          KIND_GET:    cmd_o.op = stat_i.cur_valid ? OP_READ_CUR : OP_NO_CURRENT;
          default:     cmd_o.op = OP_NONE;
        endcase
      end
      ST_SCAN: begin
        cmd_o.op = OP_SCAN;
      end
      ST_APPLY: begin
        case (stat_i.kind)
          KIND_CREATE: cmd_o.op = OP_APPLY_CREATE;
          KIND_YIELD:  cmd_o.op = OP_APPLY_YIELD;
          KIND_EXIT:   cmd_o.op = OP_APPLY_EXIT;
          KIND_START:  cmd_o.op = OP_APPLY_START;
          default:     cmd_o.op = OP_NONE;
        endcase
      end
      ST_EXIT_RUN: begin
        cmd_o.op = OP_EXIT_RUN;
      end
      ST_RMW: begin
        cmd_o.op = (stat_i.kind == KIND_SET) ? OP_SET_PRIO : OP_GET_PRIO;
      end
      ST_FINISH: begin
        cmd_o.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

FILE: sv/priority_round_robin_thread_scheduler.sv
// channel  | dir | modport | payload
// ---------+-----+---------+----------------------------------------------------------
// req_i    | in  | sink    | kind, priority_req
// rsp_o    | out | source  | status, created_slot, running_valid, running_slot,
//          |     |         | old_priority, all_done
//
// one request at a time; create and the scheduling requests (yield, exit, start)
// walk the slot table through its single read port, one slot per cycle; an exit
// that hands over to another thread then also passes through ST_EXIT_RUN; set and
// get read the current slot with no scan. per-slot valid bits make the table read as
// all free right after reset, with no clearing pass. a stalled response holds in
// the output register while the next request is already taken and worked on.

`include "priority_round_robin_thread_scheduler_assert.svh"

module priority_round_robin_thread_scheduler #(
  parameter int unsigned THREAD_SLOTS = 4
) (
  input logic       clk_i,
  input logic       rst_ni,
  prrs_req_if.sink  req_i,
  prrs_rsp_if.source rsp_o
);
  import prrs_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     req_ready;
  logic     rsp_valid;

  // sequencing
  prrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // slot table and scheduler state
  prrs_dp #(
    .THREAD_SLOTS (THREAD_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .kind_i          (req_i.kind),
    .priority_req_i  (req_i.priority_req),
    .status_o        (rsp_o.status),
    .created_slot_o  (rsp_o.created_slot),
    .running_valid_o (rsp_o.running_valid),
    .running_slot_o  (rsp_o.running_slot),
    .old_priority_o  (rsp_o.old_priority),
    .all_done_o      (rsp_o.all_done)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;

  // checks
  `PRRS_ASSERT_NXT(a_one_req, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready, "second request taken while busy")
  `PRRS_ASSERT_IMP(a_run_started, clk_i, rst_ni, dp_stat.cur_valid, dp_stat.started, "thread running before start")
  `PRRS_ASSERT_IMP(a_done_idle, clk_i, rst_ni, rsp_o.valid && rsp_o.all_done, !rsp_o.running_valid, "all done with a thread running")

endmodule
